/* src/cla_pkg.sv */
package cla_pkg;

  localparam logic [15:0] CU_NUL   = 16'h0000;
  localparam logic [15:0] CU_TAB   = 16'h0009;
  localparam logic [15:0] CU_SPACE = 16'h0020;
  localparam logic [15:0] CU_QUOTE = 16'h0022;
  localparam logic [15:0] CU_BSL   = 16'h005c;

  localparam int unsigned RUN_W = 8;

  typedef enum logic [2:0] {
    KIND_EOL   = 3'd0,
    KIND_SEP   = 3'd1,
    KIND_BSL   = 3'd2,
    KIND_QUOTE = 3'd3,
    KIND_OTHER = 3'd4
  } cla_kind_t;

  typedef struct packed {
    cla_kind_t   kind;
    logic [15:0] code;
  } cla_item_t;

  typedef struct packed {
    logic [RUN_W-1:0] lead;
    logic             char_valid;
    logic [15:0]      char_code;
    logic             arg_end;
  } cla_result_t;

endpackage

/* src/cla_in_if.sv */
interface cla_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

/* src/cla_out_if.sv */
interface cla_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  lead_backslashes;
  logic        char_valid;
  logic [15:0] char_code;
  logic        arg_end;

  modport source (
    output valid, output lead_backslashes, output char_valid, output char_code,
    output arg_end, input ready
  );
  modport sink (
    input valid, input lead_backslashes, input char_valid, input char_code,
    input arg_end, output ready
  );
endinterface

/* src/cla_front.sv */
module cla_front (
  cla_in_if.sink            in_ch,
  output logic              push_valid,
  output cla_pkg::cla_item_t push_item,
  input  logic              push_ready
);
  import cla_pkg::*;

  cla_kind_t kind;

  always_comb begin
    case (in_ch.code_unit) inside
      CU_NUL:           kind = KIND_EOL;
      CU_TAB, CU_SPACE: kind = KIND_SEP;
      CU_BSL:           kind = KIND_BSL;
      CU_QUOTE:         kind = KIND_QUOTE;
      default:          kind = KIND_OTHER;
    endcase
  end

  assign push_valid     = in_ch.valid;
  assign push_item.kind = kind;
  assign push_item.code = in_ch.code_unit;
  assign in_ch.ready    = push_ready;

endmodule

/* src/cla_queue.sv */
module cla_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  cla_pkg::cla_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output cla_pkg::cla_item_t pop_item,
  input  logic               pop_ready
);
  import cla_pkg::*;

  logic      v0_r, v1_r, v0_nxt, v1_nxt;
  cla_item_t e0_r, e1_r, e0_nxt, e1_nxt;
  logic      push, pop;

  assign push_ready = !v1_r;
  assign pop_valid  = v0_r;
  assign pop_item   = e0_r;
  assign push       = push_valid && push_ready;
  assign pop        = v0_r && pop_ready;

  // two-entry shift queue, head is always entry 0
  always_comb begin
    v0_nxt = pop ? v1_r : v0_r;
    e0_nxt = pop ? e1_r : e0_r;
    v1_nxt = pop ? 1'b0 : v1_r;
    e1_nxt = e1_r;
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        e0_nxt = push_item;
      end else begin
        v1_nxt = 1'b1;
        e1_nxt = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

/* src/cla_back.sv */
module cla_back #(
  parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  cla_pkg::cla_item_t pop_item,
  output logic               pop_ready,
  cla_out_if.source          out_ch
);
  import cla_pkg::*;

  localparam logic [RUN_W-1:0] RunCap =
    (MAX_BACKSLASH_RUN > 255) ? 8'd255 : RUN_W'(MAX_BACKSLASH_RUN);

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_INSIDE  = 2'd1,
    PH_BETWEEN = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             quote_r, quote_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             out_valid_r;
  cla_result_t      res_r, res_nxt;
  logic             emit_nxt;
  logic             fire;
  cla_kind_t        kind_eff;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign fire      = pop_valid && pop_ready;
  // a separator inside quotes is an ordinary character
  assign kind_eff  = (pop_item.kind == KIND_SEP && quote_r) ? KIND_OTHER : pop_item.kind;

  always_comb begin
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    run_nxt   = run_r;
    emit_nxt  = 1'b0;
    res_nxt   = '{lead: run_r, char_valid: 1'b0, char_code: 16'h0000, arg_end: 1'b0};
    case (kind_eff)
      KIND_EOL: begin
        emit_nxt        = (phase_r == PH_INSIDE);
        res_nxt.arg_end = 1'b1;
        phase_nxt       = PH_START;
        quote_nxt       = 1'b0;
        run_nxt         = '0;
      end
      KIND_SEP: begin
        phase_nxt = PH_BETWEEN;
        run_nxt   = '0;
        case (phase_r)
          PH_START: begin
            emit_nxt        = 1'b1;
            res_nxt.lead    = '0;
            res_nxt.arg_end = 1'b1;
          end
          PH_INSIDE: begin
            emit_nxt        = 1'b1;
            res_nxt.arg_end = 1'b1;
          end
          default: emit_nxt = 1'b0;
        endcase
      end
      KIND_BSL: begin
        phase_nxt = PH_INSIDE;
        if (run_r < RunCap) run_nxt = run_r + 1'b1;
      end
      KIND_QUOTE: begin
        phase_nxt    = PH_INSIDE;
        run_nxt      = '0;
        res_nxt.lead = run_r >> 1;
        if (!run_r[0]) begin
          emit_nxt  = |run_r[RUN_W-1:1];
          quote_nxt = !quote_r;
        end else begin
          emit_nxt           = 1'b1;
          res_nxt.char_valid = 1'b1;
          res_nxt.char_code  = CU_QUOTE;
        end
      end
      default: begin
        phase_nxt          = PH_INSIDE;
        run_nxt            = '0;
        emit_nxt           = 1'b1;
        res_nxt.char_valid = 1'b1;
        res_nxt.char_code  = pop_item.code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      quote_r     <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (fire) begin
        phase_r <= phase_nxt;
        quote_r <= quote_nxt;
        run_r   <= run_nxt;
        if (emit_nxt) begin
          out_valid_r <= 1'b1;
          res_r       <= res_nxt;
        end
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.lead_backslashes = res_r.lead;
  assign out_ch.char_valid       = res_r.char_valid;
  assign out_ch.char_code        = res_r.char_code;
  assign out_ch.arg_end          = res_r.arg_end;

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pop_item.kind == KIND_EOL) |=> (phase_r == PH_START && run_r == '0 && !quote_r))
    else $error("state not cleared at end of line");

  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= RunCap)
    else $error("backslash run above cap");

  a_char_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.char_valid && res_r.arg_end))
    else $error("result carries both character and argument end");

  a_other_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pop_item.kind == KIND_OTHER) |=> (out_valid_r && res_r.char_valid))
    else $error("plain character gave no result");

endmodule

/* src/command_line_argument_splitter_core.sv */
// Splits a command line into arguments, one 16-bit code unit per transfer,
// with the usual quote and backslash rules; a code unit of zero ends the line.
// Each input transfer yields zero or one result: a backslash count, an optional
// character and an argument-end flag. One code unit is taken every cycle while
// results are drained; a code unit passes the classifier into a two-entry queue,
// then the state update that loads the output register. The two-entry queue
// holds up to two code units while the result side stalls.
module command_line_argument_splitter_core #(
  parameter int unsigned MAX_BACKSLASH_RUN = 255
) (
  input logic       clk,
  input logic       rst_n,
  cla_in_if.sink    in_ch,
  cla_out_if.source out_ch
);
  import cla_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  cla_item_t push_item, pop_item;

  cla_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  cla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  cla_back #(
    .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
